### rtl/core/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
`default_nettype none

package cfr_pkg;

    // Action codes carried with each input beat.
    typedef logic [1:0] action_t;
    localparam action_t ACT_BYTE = 2'd0;
    localparam action_t ACT_READ = 2'd1;
    localparam action_t ACT_SKIP = 2'd2;

    // Frame receiver mode.
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_LENGTH    = 2'd1,
        MODE_RECEIVING = 2'd2,
        MODE_COMPLETE  = 2'd3
    } mode_t;

    // Seed value of the running check.
    localparam logic [7:0] CHECK_SEED = 8'hFF;

    // Register byte address index (address bit 2 selects the register word).
    localparam logic REG_FRAME_PREFIX = 1'b0;

    // Access request to the payload store.
    typedef struct packed {
        logic       we;
        logic       re;
        logic [7:0] addr;
        logic [7:0] wdata;
    } ram_req_t;

    // Result fields known at the end of the state update.
    typedef struct packed {
        logic [7:0] pending_size;
        logic       read_valid;
        logic [1:0] frame_state;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/command_frame_receiver_core.sv
// Command frame receiver: stream ports, prefix register, payload store and result pipeline.
// Pipe: the store's registered read port sets the two-stage pipe of read stage and output register.
// Throughput: one beat per cycle when the output does not stall.
// A read of the payload always follows its last write by at least one check byte,
// so store accesses never collide and need no forwarding.
// Reset clears mode, length, position, check, prefix and pipeline valids; the store is not cleared.
`default_nettype none

module command_frame_receiver_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [2:0]  s_axis_tuser,   // [1:0] action, [2] line_error
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] pending_size, [15:8] read_byte,
                                             // [17:16] frame_state, [23:18] zero
    output logic [0:0]       m_axis_tuser,   // [0] read_valid
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cfr_pkg::*;

    localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] prefix_reg;
    logic       accept;
    logic       s1_advance;
    ram_req_t   ram_req;
    result_t    ctrl_result;
    logic [7:0] ram_q;

    logic       s1_valid_reg;
    result_t    s1_result_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic [7:0] out_byte_reg;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_PREFIX) ? {24'd0, prefix_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_PREFIX)
        begin
            prefix_reg <= pwdata[7:0];
        end
    end

    // Handshake: the read stage moves on when the output register is free or taken.
    assign s1_advance    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cfr_ctrl #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action_t'(s_axis_tuser[1:0])),
        .rx_byte      (s_axis_tdata),
        .line_error   (s_axis_tuser[2]),
        .frame_prefix (prefix_reg),
        .ram_req      (ram_req),
        .result       (ctrl_result)
    );

    cfr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.addr[AddrW-1:0]),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.addr[AddrW-1:0]),
        .rdata (ram_q)
    );

    // Read stage valid and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload of the two stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg <= ctrl_result;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_result_reg <= s1_result_reg;
            out_byte_reg   <= s1_result_reg.read_valid ? ram_q : 8'd0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_result_reg.frame_state, out_byte_reg,
                            out_result_reg.pending_size};
    assign m_axis_tuser  = out_result_reg.read_valid;

    // The store is never written and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("payload store written and read in one cycle");

    // A stalled read beat keeps its store data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_result_reg.read_valid && !s1_advance) |=>
            (s1_valid_reg && $stable(ram_q)))
        else $error("store data lost while the read stage was stalled");

    // A complete frame always reports a non-zero pending length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_result_reg.frame_state == MODE_COMPLETE) ==
             (out_result_reg.pending_size != 8'd0)))
        else $error("pending length does not match frame state");

endmodule

`default_nettype wire

### rtl/core/cfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/cfr_ctrl.sv
// Frame state update: mode, length, position and running check, plus store requests.
`default_nettype none

module cfr_ctrl #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire cfr_pkg::action_t   action,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               line_error,
    input  wire logic [7:0]         frame_prefix,
    output cfr_pkg::ram_req_t       ram_req,
    output cfr_pkg::result_t        result
);
    import cfr_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    mode_t      mode_reg,   mode_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] pos_reg,    pos_next;
    logic [7:0] check_reg,  check_next;
    logic [7:0] mixed;
    logic       is_prefix;
    mode_t      resync_mode;

    assign is_prefix   = (rx_byte == frame_prefix);
    assign resync_mode = is_prefix ? MODE_LENGTH : MODE_IDLE;
    assign mixed       = check_reg ^ rx_byte;

    // Next-state logic for one accepted beat.
    always_comb
    begin
        mode_next   = mode_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        check_next  = check_reg;
        ram_req     = '0;
        ram_req.addr  = pos_reg;
        ram_req.wdata = rx_byte;
        result.read_valid = 1'b0;
        if (accept)
        begin
            case (action)
                ACT_BYTE:
                begin
                    if (mode_reg != MODE_COMPLETE)
                    begin
                        if (line_error)
                        begin
                            mode_next = resync_mode;
                        end
                        else
                        begin
                            case (mode_reg)
                                MODE_IDLE:
                                begin
                                    if (is_prefix)
                                    begin
                                        mode_next = MODE_LENGTH;
                                    end
                                end
                                MODE_LENGTH:
                                begin
                                    if (rx_byte != 8'd0 && rx_byte <= MaxLen)
                                    begin
                                        length_next = rx_byte;
                                        pos_next    = 8'd0;
                                        check_next  = CHECK_SEED;
                                        mode_next   = MODE_RECEIVING;
                                    end
                                    else if (!is_prefix)
                                    begin
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                default:
                                begin
                                    // Receiving: payload bytes, then the check byte.
                                    if (pos_reg < length_reg)
                                    begin
                                        ram_req.we = 1'b1;
                                        pos_next   = pos_reg + 8'd1;
                                        check_next = {mixed[6:0], mixed[7]};
                                    end
                                    else if (check_reg == rx_byte)
                                    begin
                                        pos_next  = 8'd0;
                                        mode_next = MODE_COMPLETE;
                                    end
                                    else
                                    begin
                                        mode_next = resync_mode;
                                    end
                                end
                            endcase
                        end
                    end
                end
                ACT_READ:
                begin
                    if (mode_reg == MODE_COMPLETE && pos_reg < length_reg)
                    begin
                        ram_req.re        = 1'b1;
                        result.read_valid = 1'b1;
                        pos_next          = pos_reg + 8'd1;
                        if (pos_next == length_reg)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                ACT_SKIP:
                begin
                    if (mode_reg == MODE_COMPLETE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    // Unused action leaves the state alone.
                end
            endcase
        end
        result.frame_state  = mode_next;
        result.pending_size = (mode_next == MODE_COMPLETE) ? length_next : 8'd0;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            length_reg <= 8'd0;
            pos_reg    <= 8'd0;
            check_reg  <= CHECK_SEED;
        end
        else
        begin
            mode_reg   <= mode_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            check_reg  <= check_next;
        end
    end

endmodule

`default_nettype wire
